// File: hw/rtl/tfd_pkg.sv
package tfd_pkg;

  // Tag and framing constants
  localparam logic [7:0]  BYTE_DOLLAR = 8'h24;
  localparam logic [31:0] TAG_ROV     = 32'h24524F56;
  localparam logic [31:0] TAG_REF     = 32'h24524546;
  localparam logic [31:0] TAG_IMU     = 32'h24494D55;
  localparam logic [31:0] TAG_BAS     = 32'h24424153;
  localparam logic [7:0]  IMU_SYNC0   = 8'hD4;
  localparam logic [7:0]  IMU_SYNC1   = 8'h34;
  localparam logic [7:0]  CRC_POLY    = 8'h8C;
  localparam logic [7:0]  ASCII_ZERO  = 8'd48;
  localparam logic [7:0]  ASCII_NINE  = 8'd57;
  localparam logic [7:0]  ASCII_PLUS  = 8'h2B;
  localparam logic [7:0]  ASCII_MINUS = 8'h2D;
  localparam logic [7:0]  ASCII_SPACE = 8'h20;
  localparam logic [7:0]  ASCII_TAB   = 8'h09;
  localparam logic [7:0]  ASCII_CR    = 8'h0D;

  localparam int unsigned POS_W      = 10;
  localparam int unsigned LEN_W      = 10;
  localparam int unsigned TAG_LEN    = 4;
  localparam int unsigned HL_ROV     = 8;
  localparam int unsigned HL_OTHER   = 7;
  localparam int unsigned IMU_BODY   = 23;
  localparam int unsigned IMU_STORE  = IMU_BODY - 1;   // the CRC byte is never stored
  localparam int unsigned IMU_IDX_W  = $clog2(IMU_STORE);
  localparam int unsigned CRC_FIRST  = 2;
  localparam int unsigned CRC_LAST   = 21;
  localparam int unsigned FIELD_BYTES = CRC_LAST - CRC_FIRST + 1;
  localparam int unsigned FIELD_W    = FIELD_BYTES * 8;
  localparam int unsigned IMU_END_POS = TAG_LEN + IMU_BODY - 1;

  localparam int unsigned TIME_W = 28;
  localparam int unsigned ACC_W  = 20;
  localparam int unsigned RATE_W = 24;
  localparam int unsigned KIND_W = 3;

  // Record kinds
  localparam logic [KIND_W-1:0] KIND_ROV1      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ROV_OTHER = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REF       = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BAS       = 3'd5;
  localparam logic [KIND_W-1:0] KIND_IMU       = 3'd6;

  typedef enum logic [2:0] {
    FT_NONE = 3'd0,
    FT_ROV  = 3'd1,
    FT_IMU  = 3'd2,
    FT_REF  = 3'd3,
    FT_BAS  = 3'd4
  } ftype_e;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } parse_ph_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_stage_t;

  typedef struct packed {
    logic [KIND_W-1:0]        record_kind;
    logic [7:0]               payload_byte;
    logic                     last_byte;
    logic [TIME_W-1:0]        imu_time;
    logic signed [ACC_W-1:0]  accel_x;
    logic signed [ACC_W-1:0]  accel_y;
    logic signed [ACC_W-1:0]  accel_z;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
  } rec_t;

  typedef struct packed {
    logic             ok;
    logic [LEN_W-1:0] len;
  } len_t;

  // Reflected CRC-8, one byte, unrolled
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return (ch == ASCII_SPACE) || ((ch >= ASCII_TAB) && (ch <= ASCII_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= ASCII_ZERO) && (ch <= ASCII_NINE);
  endfunction

  // atoi over three characters, first char in bits 23:16
  function automatic len_t parse_length(input logic [23:0] d);
    len_t       r;
    parse_ph_e  ph;
    logic       neg;
    logic [7:0] ch;
    logic [3:0] dig;
    logic [LEN_W-1:0] v;
    ph  = PH_SKIP;
    neg = 1'b0;
    v   = '0;
    for (int j = 0; j < 3; j++) begin
      ch  = d[23-8*j -: 8];
      dig = 4'(ch - ASCII_ZERO);
      case (ph)
        PH_SKIP: begin
          if (is_space(ch)) begin
            ph = PH_SKIP;
          end else if (ch == ASCII_PLUS || ch == ASCII_MINUS) begin
            neg = (ch == ASCII_MINUS);
            ph  = PH_DIGITS;
          end else if (is_digit(ch)) begin
            v  = LEN_W'(v * LEN_W'(10) + LEN_W'(dig));
            ph = PH_DIGITS;
          end else begin
            ph = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit(ch)) begin
            v = LEN_W'(v * LEN_W'(10) + LEN_W'(dig));
          end else begin
            ph = PH_DONE;
          end
        end
        default: ph = PH_DONE;
      endcase
    end
    r.ok  = (v != '0) && !neg;
    r.len = v;
    return r;
  endfunction

endpackage

// File: hw/rtl/tfd_byte_if.sv
interface tfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// File: hw/rtl/tfd_rec_if.sv
interface tfd_rec_if import tfd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        record_kind;
  logic [7:0]               payload_byte;
  logic                     last_byte;
  logic [TIME_W-1:0]        imu_time;
  logic signed [ACC_W-1:0]  accel_x;
  logic signed [ACC_W-1:0]  accel_y;
  logic signed [ACC_W-1:0]  accel_z;
  logic signed [RATE_W-1:0] rate_x;
  logic signed [RATE_W-1:0] rate_y;
  logic signed [RATE_W-1:0] rate_z;

  modport source (output valid, output record_kind, output payload_byte, output last_byte,
                  output imu_time, output accel_x, output accel_y, output accel_z,
                  output rate_x, output rate_y, output rate_z, input ready);
  modport sink   (input valid, input record_kind, input payload_byte, input last_byte,
                  input imu_time, input accel_x, input accel_y, input accel_z,
                  input rate_x, input rate_y, input rate_z, output ready);
endinterface

// File: hw/rtl/tfd_in_stage.sv
module tfd_in_stage import tfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [7:0]  byte_i,
  output logic        ready_o,
  input  logic        free_i,
  output byte_stage_t stage_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       take;

  assign ready_o = !valid_q || free_i;
  assign take    = valid_i && ready_o;
  assign valid_d = take || (valid_q && !free_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= byte_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

// File: hw/rtl/tfd_parser.sv
module tfd_parser import tfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  byte_stage_t stage_i,
  input  logic        free_i,
  output logic        res_valid_o,
  output rec_t        res_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  ftype_e           ftype_q, ftype_d;
  logic [31:0]      tag_q, tag_d;
  logic [7:0]       stream_q, stream_d;
  logic [LEN_W-1:0] plen_q, plen_d;
  logic             ldone_q, ldone_d;
  logic [7:0]       crc_q, crc_d;
  logic [7:0]       imu_buf_q [IMU_STORE];

  logic             fire;
  logic [7:0]       b;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] k;
  logic [POS_W-1:0] hl;
  logic [31:0]      tag_shift;
  logic             is_stream;
  logic             last_hit;
  logic             imu_we;
  logic             clr;
  len_t             parsed;
  logic [FIELD_W-1:0] body;

  assign fire      = stage_i.valid && free_i;
  assign b         = stage_i.data;
  assign pos_inc   = POS_W'(pos_q + POS_W'(1));
  assign k         = POS_W'(pos_q - POS_W'(TAG_LEN));
  assign hl        = (ftype_q == FT_ROV) ? POS_W'(HL_ROV) : POS_W'(HL_OTHER);
  assign tag_shift = {tag_q[23:0], b};
  assign is_stream = (ftype_q == FT_ROV) || (ftype_q == FT_REF) || (ftype_q == FT_BAS);
  assign last_hit  = {1'b0, pos_inc} >= ({1'b0, hl} + {1'b0, plen_q});
  assign parsed    = parse_length(tag_shift[23:0]);

  // next state
  always_comb begin
    pos_d    = pos_q;
    ftype_d  = ftype_q;
    tag_d    = tag_q;
    stream_d = stream_q;
    plen_d   = plen_q;
    ldone_d  = ldone_q;
    crc_d    = crc_q;
    imu_we   = 1'b0;
    clr      = 1'b0;
    if (fire) begin
      if (pos_q == '0) begin
        if (b == BYTE_DOLLAR) begin
          tag_d = {24'd0, b};
          pos_d = POS_W'(1);
        end
      end else if (pos_q < POS_W'(TAG_LEN)) begin
        tag_d = tag_shift;
        pos_d = pos_inc;
        if (pos_inc == POS_W'(TAG_LEN)) begin
          case (tag_shift)
            TAG_ROV: ftype_d = FT_ROV;
            TAG_REF: ftype_d = FT_REF;
            TAG_IMU: ftype_d = FT_IMU;
            TAG_BAS: ftype_d = FT_BAS;
            default: ftype_d = FT_NONE;
          endcase
          if (ftype_d != FT_NONE) begin
            tag_d = '0;
          end
          crc_d = '0;
        end
      end else if (ftype_q == FT_IMU) begin
        if (k >= POS_W'(IMU_BODY)) begin
          clr = 1'b1;
        end else begin
          imu_we = (k < POS_W'(IMU_STORE));
          if (k >= POS_W'(CRC_FIRST) && k <= POS_W'(CRC_LAST)) begin
            crc_d = crc8_byte(crc_q, b);
          end
          pos_d = pos_inc;
          if (k == POS_W'(IMU_BODY - 1)) begin
            clr = 1'b1;
          end
        end
      end else if (!is_stream) begin
        clr = 1'b1;   // unknown tag: swallow this byte
      end else if (!ldone_q) begin
        if (ftype_q == FT_ROV && pos_q == POS_W'(TAG_LEN)) begin
          stream_d = 8'(b - ASCII_ZERO);
        end else begin
          tag_d = {8'd0, tag_shift[23:0]};
        end
        pos_d = pos_inc;
        if (pos_inc >= hl) begin
          if (parsed.ok) begin
            plen_d  = parsed.len;
            ldone_d = 1'b1;
          end else begin
            clr = 1'b1;
          end
        end
      end else begin
        pos_d = pos_inc;
        if (last_hit) begin
          clr = 1'b1;
        end
      end
    end
    if (clr) begin
      pos_d    = '0;
      ftype_d  = FT_NONE;
      tag_d    = '0;
      stream_d = '0;
      plen_d   = '0;
      ldone_d  = 1'b0;
      crc_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      ftype_q  <= FT_NONE;
      tag_q    <= '0;
      stream_q <= '0;
      plen_q   <= '0;
      ldone_q  <= 1'b0;
      crc_q    <= '0;
    end else begin
      pos_q    <= pos_d;
      ftype_q  <= ftype_d;
      tag_q    <= tag_d;
      stream_q <= stream_d;
      plen_q   <= plen_d;
      ldone_q  <= ldone_d;
      crc_q    <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (imu_we) begin
      imu_buf_q[k[IMU_IDX_W-1:0]] <= b;
    end
  end

  // body bytes 2..21, MSB first
  always_comb begin
    for (int j = 0; j < FIELD_BYTES; j++) begin
      body[(FIELD_BYTES-1-j)*8 +: 8] = imu_buf_q[j+CRC_FIRST];
    end
  end

  // result
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (fire && pos_q >= POS_W'(TAG_LEN)) begin
      if (ftype_q == FT_IMU) begin
        if (k == POS_W'(IMU_BODY - 1) && imu_buf_q[0] == IMU_SYNC0 &&
            imu_buf_q[1] == IMU_SYNC1 && crc_q == b) begin
          res_valid_o       = 1'b1;
          res_o.record_kind = KIND_IMU;
          res_o.last_byte   = 1'b1;
          res_o.imu_time    = body[FIELD_W-1 -: TIME_W];
          res_o.accel_x     = $signed(body[FIELD_W-TIME_W-1 -: ACC_W]);
          res_o.accel_y     = $signed(body[FIELD_W-TIME_W-ACC_W-1 -: ACC_W]);
          res_o.accel_z     = $signed(body[FIELD_W-TIME_W-2*ACC_W-1 -: ACC_W]);
          res_o.rate_x      = $signed(body[3*RATE_W-1 -: RATE_W]);
          res_o.rate_y      = $signed(body[2*RATE_W-1 -: RATE_W]);
          res_o.rate_z      = $signed(body[RATE_W-1 -: RATE_W]);
        end
      end else if (is_stream && ldone_q) begin
        res_valid_o        = 1'b1;
        res_o.payload_byte = b;
        res_o.last_byte    = last_hit;
        case (ftype_q)
          FT_ROV: begin
            if (stream_q >= 8'd1 && stream_q <= 8'd3) begin
              res_o.record_kind = KIND_W'(KIND_ROV1 + KIND_W'(stream_q - 8'd1));
            end else begin
              res_o.record_kind = KIND_ROV_OTHER;
            end
          end
          FT_REF:  res_o.record_kind = KIND_REF;
          default: res_o.record_kind = KIND_BAS;
        endcase
      end
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_byte |=> pos_q == '0)
    else $error("frame state not cleared after last word");

  a_imu_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.record_kind == KIND_IMU |->
      ftype_q == FT_IMU && pos_q == POS_W'(IMU_END_POS))
    else $error("imu record outside final body byte");

  a_len_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ldone_q |-> plen_q != '0 && is_stream)
    else $error("payload phase without a valid length");

  a_unknown_swallow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && pos_q >= POS_W'(TAG_LEN) && ftype_q == FT_NONE |=> pos_q == '0)
    else $error("unknown tag did not resync");

endmodule

// File: hw/rtl/tfd_out_stage.sv
module tfd_out_stage import tfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  input  rec_t res_i,
  output logic free_o,
  output logic valid_o,
  input  logic ready_i,
  output rec_t rec_o
);

  logic valid_q;
  rec_t rec_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_valid_i) begin
      rec_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign rec_o   = rec_q;

endmodule

// File: hw/rtl/tagged_frame_demux_imu_decoder.sv
// Path: an accepted byte goes into the input register, then its word into the
//   result register, which drives the output.
// Throughput: one byte per cycle, sustained while the output side keeps up.
// Reset (async, active low): framing state cleared, block hunts for '$'.
//   The IMU body buffer is not reset; it is always written before use.
module tagged_frame_demux_imu_decoder import tfd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  tfd_byte_if.sink  in_i,
  tfd_rec_if.source out_o
);

  byte_stage_t stage;
  logic        free;
  logic        res_valid;
  rec_t        res;
  rec_t        rec;

  // Input register: holds one byte; refills in the same cycle it drains.
  tfd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .byte_i  (in_i.byte_in),
    .ready_o (in_i.ready),
    .free_i  (free),
    .stage_o (stage)
  );

  // Framer: tag match, header/length parse, payload tagging, IMU CRC and
  // field extraction, all in one combinational pass per byte.
  tfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .free_i      (free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register: free when empty or being taken this cycle.
  tfd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (free),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .rec_o       (rec)
  );

  assign out_o.record_kind  = rec.record_kind;
  assign out_o.payload_byte = rec.payload_byte;
  assign out_o.last_byte    = rec.last_byte;
  assign out_o.imu_time     = rec.imu_time;
  assign out_o.accel_x      = rec.accel_x;
  assign out_o.accel_y      = rec.accel_y;
  assign out_o.accel_z      = rec.accel_z;
  assign out_o.rate_x       = rec.rate_x;
  assign out_o.rate_y       = rec.rate_y;
  assign out_o.rate_z       = rec.rate_z;

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfd_pkg::*;

  // How an IMU body is spoiled on purpose
  typedef enum int {
    IMU_GOOD,
    IMU_BAD_SYNC,
    IMU_BAD_CRC
  } imu_fault_e;

  logic clk_i;
  logic rst_ni;

  tfd_byte_if byte_bus ();
  tfd_rec_if  rec_bus ();

  tagged_frame_demux_imu_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_bus),
    .out_o  (rec_bus)
  );

  // ---------------------------------------------------------------------------
  // Framer mirror: our own copy of the parse state, stepped once per accepted
  // input word.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] fr_pos;        // bytes taken in this frame, 0 = hunting
  ftype_e           fr_type;
  logic [31:0]      fr_tag;        // tag, later the three length characters
  logic [7:0]       fr_stream;     // ROV stream digit minus '0', wraps
  logic [LEN_W-1:0] fr_len;
  logic             fr_len_done;
  logic [7:0]       fr_crc;
  logic [7:0]       imu_body [IMU_BODY];

  // Records still owed by the block, oldest first
  rec_t pending_recs[$];
  rec_t want_rec;

  int n_errors    = 0;
  int n_bytes     = 0;  // every input word
  int n_framed    = 0;  // input words the framer did not simply ignore
  int n_payload   = 0;
  int n_imu       = 0;

  int send_idle_pct     = 19;
  int recv_idle_pct     = 76;
  int long_stall_cycles = 0;

  function automatic void restart_hunt();
    fr_pos      = '0;
    fr_type     = FT_NONE;
    fr_tag      = '0;
    fr_stream   = '0;
    fr_len      = '0;
    fr_len_done = 1'b0;
    fr_crc      = '0;
  endfunction

  // Reflected CRC-8, one data bit at a time, LSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // atoi over three characters; false on zero or a minus sign
  function automatic logic ascii_len(input logic [23:0] txt, output logic [LEN_W-1:0] len);
    logic [7:0] ch [3];
    int         i;
    int         v;
    logic       minus;
    ch[0] = txt[23:16];
    ch[1] = txt[15:8];
    ch[2] = txt[7:0];
    i     = 0;
    v     = 0;
    minus = 1'b0;
    while (i < 3 && (ch[i] == ASCII_SPACE || (ch[i] >= ASCII_TAB && ch[i] <= ASCII_CR))) i++;
    if (i < 3 && (ch[i] == ASCII_PLUS || ch[i] == ASCII_MINUS)) begin
      minus = (ch[i] == ASCII_MINUS);
      i++;
    end
    while (i < 3 && ch[i] >= ASCII_ZERO && ch[i] <= ASCII_NINE) begin
      v = v * 10 + int'(ch[i] - ASCII_ZERO);
      i++;
    end
    len = LEN_W'(v);
    return (v != 0) && !minus;
  endfunction

  // Steps the mirror by one byte; returns 1 when the byte yields a record
  function automatic logic decode_byte(input logic [7:0] c, output rec_t r);
    logic [LEN_W-1:0] len;
    logic             ok;
    logic [175:0]     flat;
    int               k;
    int               hl;
    r = '0;

    // hunting: only '$' opens a frame
    if (fr_pos == 0) begin
      if (c == BYTE_DOLLAR) begin
        fr_tag = {24'h0, c};
        fr_pos = 1;
      end
      return 1'b0;
    end

    // rest of the four-byte tag
    if (fr_pos < TAG_LEN) begin
      fr_tag = {fr_tag[23:0], c};
      fr_pos = fr_pos + 1'b1;
      if (fr_pos == TAG_LEN) begin
        case (fr_tag)
          TAG_ROV: fr_type = FT_ROV;
          TAG_REF: fr_type = FT_REF;
          TAG_IMU: fr_type = FT_IMU;
          TAG_BAS: fr_type = FT_BAS;
          default: fr_type = FT_NONE;
        endcase
        if (fr_type != FT_NONE) fr_tag = '0;
        fr_crc = '0;
      end
      return 1'b0;
    end

    if (fr_type == FT_IMU) begin
      k = int'(fr_pos) - int'(TAG_LEN);
      imu_body[k] = c;
      if (k >= CRC_FIRST && k <= CRC_LAST) fr_crc = crc8_update(fr_crc, c);
      fr_pos = fr_pos + 1'b1;
      if (k < IMU_BODY - 1) return 1'b0;
      ok = imu_body[0] == IMU_SYNC0 && imu_body[1] == IMU_SYNC1 && fr_crc == imu_body[22];
      restart_hunt();
      if (!ok) return 1'b0;
      // body bytes 0..21 as one MSB-first bit string
      flat = '0;
      for (int i = 0; i < 22; i++) flat = {flat[167:0], imu_body[i]};
      r.record_kind = KIND_IMU;
      r.last_byte   = 1'b1;
      r.imu_time    = flat[159 -: TIME_W];
      r.accel_x     = flat[131 -: ACC_W];
      r.accel_y     = flat[111 -: ACC_W];
      r.accel_z     = flat[91 -: ACC_W];
      r.rate_x      = flat[71 -: RATE_W];
      r.rate_y      = flat[47 -: RATE_W];
      r.rate_z      = flat[23 -: RATE_W];
      return 1'b1;
    end

    // unknown tag: this byte is swallowed
    if (fr_type == FT_NONE) begin
      restart_hunt();
      return 1'b0;
    end

    hl = (fr_type == FT_ROV) ? HL_ROV : HL_OTHER;
    if (!fr_len_done) begin
      if (fr_type == FT_ROV && fr_pos == TAG_LEN) fr_stream = c - ASCII_ZERO;
      else fr_tag = {8'h00, fr_tag[15:0], c};
      fr_pos = fr_pos + 1'b1;
      if (int'(fr_pos) >= hl) begin
        if (ascii_len(fr_tag[23:0], len)) begin
          fr_len      = len;
          fr_len_done = 1'b1;
        end else begin
          restart_hunt();
        end
      end
      return 1'b0;
    end

    // payload: the length alone ends the frame, '$' is plain data here
    fr_pos = fr_pos + 1'b1;
    case (fr_type)
      FT_ROV: begin
        if (fr_stream >= 1 && fr_stream <= 3) r.record_kind = KIND_W'(KIND_ROV1 + fr_stream - 1);
        else r.record_kind = KIND_ROV_OTHER;
      end
      FT_REF:  r.record_kind = KIND_REF;
      default: r.record_kind = KIND_BAS;
    endcase
    r.payload_byte = c;
    r.last_byte    = int'(fr_pos) >= hl + int'(fr_len);
    if (r.last_byte) restart_hunt();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, receiver side, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Output ready: random per cycle, or held low for a counted stretch
  initial begin
    rec_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall_cycles > 0) begin
        rec_bus.ready <= 1'b0;
        long_stall_cycles--;
      end else begin
        rec_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #5ms;
    $display("timeout, %0d records still owed", pending_recs.size());
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= 30) $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Every output word taken is matched against the oldest owed record
  always @(posedge clk_i) begin
    if (rst_ni && rec_bus.valid && rec_bus.ready) begin
      if (pending_recs.size() == 0) begin
        report_mismatch("word with none owed, kind", rec_bus.record_kind, '0);
      end else begin
        want_rec = pending_recs.pop_front();
        if (want_rec.record_kind == KIND_IMU) n_imu++;
        else n_payload++;
        check_field("record_kind",  rec_bus.record_kind,  want_rec.record_kind);
        check_field("payload_byte", rec_bus.payload_byte, want_rec.payload_byte);
        check_field("last_byte",    rec_bus.last_byte,    want_rec.last_byte);
        check_field("imu_time",     rec_bus.imu_time,     want_rec.imu_time);
        check_field("accel_x",      rec_bus.accel_x,      want_rec.accel_x);
        check_field("accel_y",      rec_bus.accel_y,      want_rec.accel_y);
        check_field("accel_z",      rec_bus.accel_z,      want_rec.accel_z);
        check_field("rate_x",       rec_bus.rate_x,       want_rec.rate_x);
        check_field("rate_y",       rec_bus.rate_y,       want_rec.rate_y);
        check_field("rate_z",       rec_bus.rate_z,       want_rec.rate_z);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sending
  // ---------------------------------------------------------------------------
  // Offers one input word after a random gap and steps the mirror once the
  // word is taken. Called right after a rising edge; returns right after one.
  task automatic send_byte(input logic [7:0] b);
    rec_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_bus.valid   <= 1'b1;
    byte_bus.byte_in <= b;
    @(posedge clk_i);
    while (!byte_bus.ready) @(posedge clk_i);
    n_bytes++;
    if (fr_pos != 0 || b == BYTE_DOLLAR) n_framed++;
    if (decode_byte(b, r)) pending_recs.push_back(r);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_payload(input int n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // fields: time, accel x/y/z, rate x/y/z, packed MSB first (160 bits)
  task automatic send_imu(input logic [159:0] fields, input imu_fault_e fault);
    logic [7:0] body [IMU_BODY];
    logic [7:0] crc;
    body[0] = IMU_SYNC0;
    body[1] = IMU_SYNC1;
    crc     = '0;
    for (int i = 0; i < 20; i++) begin
      body[2+i] = fields[159-8*i -: 8];
      crc       = crc8_update(crc, body[2+i]);
    end
    body[22] = crc;
    if (fault == IMU_BAD_SYNC) body[$urandom_range(1)] ^= 8'(1 << $urandom_range(7));
    if (fault == IMU_BAD_CRC) body[22] ^= 8'(1 << $urandom_range(7));
    send_text("$IMU");
    foreach (body[i]) send_byte(body[i]);
  endtask

  // Three length characters in one of the forms atoi accepts
  function automatic string len_text(input int n);
    if (n < 100 && $urandom_range(3) == 0) return $sformatf("+%02d", n);
    if (n < 100 && $urandom_range(2) == 0) return $sformatf(" %2d", n);
    return $sformatf("%03d", n);
  endfunction

  // Input idles, then waits until every owed record has come out
  task automatic drain_results();
    byte_bus.valid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Hunting, the ROV, REF and BAS tags with every stream kind, '$' inside payload, unknown tags
  task automatic test_tags_and_streams();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("ROV");                        // no '$': ignored
    send_text("$ROV1001");
    send_byte(8'hFF);
    send_text("$ROV2002");
    send_byte(8'h00);
    send_byte(BYTE_DOLLAR);                  // payload '$' does not resync
    send_text("$ROV3001");
    send_payload(1);
    send_text("$ROV9001");                   // other stream
    send_payload(1);
    send_text("$ROV/001");                   // stream digit wraps below '0'
    send_payload(1);
    send_text("$REF001");
    send_payload(1);
    send_text("$BAS003");
    send_payload(3);
    send_text("$XYZ$");                      // unknown tag swallows the '$'
    send_text("$REF001");
    send_payload(1);
    send_text("$$ROV");                      // '$' inside a tag is not a restart
    send_text("$BAS001");
    send_payload(1);
    drain_results();
  endtask

  // Length field forms, and headers that discard the frame
  task automatic test_length_fields();
    send_text("$REF 12");
    send_payload(12);
    send_text("$BAS+05");
    send_payload(5);
    send_text("$ROV1  7");
    send_payload(7);
    send_text("$REF7x9");                    // digits stop at the first non-digit
    send_payload(7);
    send_text("$ROV2\t+2");
    send_payload(2);
    send_text("$REF000");                    // zero length
    send_text("$BAS-05");                    // negative
    send_text("$REFabc");                    // no digits
    send_text("$BAS   ");                    // blanks only
    send_text("$REF+-1");                    // two signs
    send_text("$ROV3-00");
    send_text("$BAS002");
    send_payload(2);
    drain_results();
  endtask

  // IMU records at the field extremes, plus sync and CRC faults
  task automatic test_imu_records();
    send_imu({28'hFFFFFFF, 20'h7FFFF, 20'h80000, 20'h00000,
              24'h7FFFFF, 24'h800000, 24'hFFFFFF}, IMU_GOOD);
    send_imu({28'h0000000, 20'h80000, 20'h7FFFF, 20'hFFFFF,
              24'h800000, 24'h7FFFFF, 24'h000000}, IMU_GOOD);
    send_imu({$urandom, $urandom, $urandom, $urandom, $urandom}, IMU_BAD_SYNC);
    send_imu({$urandom, $urandom, $urandom, $urandom, $urandom}, IMU_BAD_CRC);
    send_imu({$urandom, $urandom, $urandom, $urandom, $urandom}, IMU_GOOD);
    drain_results();
  endtask

  // Receiver holds off while a maximum-length frame streams in back to back,
  // so the block fills and stalls its input; then the sender waits it out.
  task automatic test_output_stall();
    int saved_idle;
    saved_idle        = send_idle_pct;
    send_idle_pct     = 0;
    long_stall_cycles = 400;
    send_text("$BAS999");
    send_payload(999);
    send_idle_pct = saved_idle;
    drain_results();
  endtask

  task automatic send_noise();
    string pool;
    pool = " +-059a";
    case ($urandom_range(3))
      0: repeat ($urandom_range(8, 1)) send_byte(8'($urandom));
      1: begin
        // broken or odd length field
        send_text($urandom_range(1) ? "$REF" : "$BAS");
        repeat (3) send_byte($urandom_range(3) ? pool[$urandom_range(6)] : 8'($urandom));
        send_payload($urandom_range(4));
      end
      2: begin
        send_byte(BYTE_DOLLAR);
        send_payload(4);
      end
      default: begin
        // cut-short IMU body; whatever follows is taken as body
        send_text("$IMU");
        send_payload($urandom_range(22, 1));
      end
    endcase
  endtask

  // Mostly well-formed frames with random content, the rest noise
  task automatic test_random_traffic(input int s_idle, input int r_idle, input int n_words);
    int start;
    int pick;
    int n;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    start         = n_framed;
    while (n_framed - start < n_words) begin
      pick = $urandom_range(99);
      n    = ($urandom_range(9) == 0) ? $urandom_range(120, 13) : $urandom_range(12, 1);
      if (pick < 30) begin
        send_text("$ROV");
        send_byte(($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(51, 49)));
        send_text(len_text(n));
        send_payload(n);
      end else if (pick < 60) begin
        send_text((pick < 45) ? "$REF" : "$BAS");
        send_text(len_text(n));
        send_payload(n);
      end else if (pick < 85) begin
        pick = $urandom_range(9);
        send_imu({$urandom, $urandom, $urandom, $urandom, $urandom},
                 (pick == 0) ? IMU_BAD_SYNC : (pick == 1) ? IMU_BAD_CRC : IMU_GOOD);
      end else begin
        send_noise();
      end
    end
    drain_results();
  endtask

  task automatic finish_run();
    rec_t lost;
    int   waited;
    byte_bus.valid <= 1'b0;
    waited = 0;
    while (pending_recs.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    while (pending_recs.size() != 0) begin
      lost = pending_recs.pop_front();
      report_mismatch("record never delivered, kind", '0, lost.record_kind);
    end
    $display("Sent %0d input words (%0d inside frames); checked %0d payload and %0d IMU records.",
             n_bytes, n_framed, n_payload, n_imu);
    $display("Tags, stream digits, length forms, bad headers, IMU faults and a long output stall.");
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni           <= 1'b0;
    byte_bus.valid   <= 1'b0;
    byte_bus.byte_in <= '0;
    restart_hunt();
    foreach (imu_body[i]) imu_body[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_tags_and_streams();
    test_length_fields();
    test_imu_records();
    test_output_stall();
    // sender busy/receiver slow, then the reverse, then full rate
    test_random_traffic(19, 76, 220);
    test_random_traffic(76, 19, 220);
    test_random_traffic(0, 0, 220);
    finish_run();
  end

endmodule

// File: tagged_frame_demux_imu_decoder.f
hw/rtl/tfd_pkg.sv
hw/rtl/tfd_byte_if.sv
hw/rtl/tfd_rec_if.sv
hw/rtl/tfd_in_stage.sv
hw/rtl/tfd_parser.sv
hw/rtl/tfd_out_stage.sv
hw/rtl/tagged_frame_demux_imu_decoder.sv
tb/tb.sv
